[src/frot_pkg.sv]
package frot_pkg;

   localparam int MAX_ROWS = 256;
   localparam int MAX_COLS = 256;

   // Row and column indexes share one width; a bank is MAX_ROWS x 2**IDX_W entries.
   localparam int IDX_W = $clog2((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS);
   localparam int ADDR_W = 1 + 2 * IDX_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;

   localparam int CH_W = 8;
   localparam int PIX_W = 3 * CH_W;
   localparam int SIZE_W = 9;
   localparam int TURN_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_QUARTER_TURNS = CSR_IDX_W'(2);

   localparam logic [SIZE_W-1:0] RESET_ROWS = SIZE_W'(256);
   localparam logic [SIZE_W-1:0] RESET_COLS = SIZE_W'(256);

   typedef enum logic [TURN_W-1:0] {
      TURN_0,
      TURN_90,
      TURN_180,
      TURN_270
   } turn_type;

   // Memory access for one accepted word, plus the flags that travel with its read.
   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr;
      logic [ADDR_W-1:0] wr_addr;
      logic              filled;
      logic              end_of_row;
      logic              end_of_frame;
   } frot_access_type;

   // Last valid index for a programmed size: zero acts as one, oversize saturates.
   function automatic logic [IDX_W-1:0] last_index(input logic [SIZE_W-1:0] size,
                                                   input int bound);
      if (size == '0) begin
         return '0;
      end else if (size > SIZE_W'(bound)) begin
         return IDX_W'(bound - 1);
      end else begin
         return IDX_W'(size - 1'b1);
      end
   endfunction

endpackage

[src/frot_if.sv]
interface frot_req_if;
   import frot_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] in_red;
   logic [CH_W-1:0] in_green;
   logic [CH_W-1:0] in_blue;

   modport source (output valid, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink (input valid, input in_red, input in_green, input in_blue,
                 output ready);
endinterface

interface frot_rsp_if;
   import frot_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_red;
   logic [CH_W-1:0] out_green;
   logic [CH_W-1:0] out_blue;
   logic            out_valid;
   logic            end_of_row;
   logic            end_of_frame;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output out_valid, output end_of_row, output end_of_frame,
                   input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 input out_valid, input end_of_row, input end_of_frame,
                 output ready);
endinterface

[src/frot_frame_ram.sv]
module frot_frame_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [frot_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [frot_pkg::PIX_W-1:0]   wr_data,
   input  logic                         rd_en,
   input  logic [frot_pkg::ADDR_W-1:0]  rd_addr,
   output logic [frot_pkg::PIX_W-1:0]   rd_data
);
   import frot_pkg::*;

   logic [PIX_W-1:0] mem [0:MEM_DEPTH-1];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data register holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/frot_seq.sv]
module frot_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [frot_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [frot_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            accept,
   output frot_pkg::frot_access_type       access
);
   import frot_pkg::*;

   logic [IDX_W-1:0] row_last_ff, row_last_in;
   logic [IDX_W-1:0] col_last_ff, col_last_in;
   turn_type         turns_ff, turns_in;
   logic [IDX_W-1:0] write_row_ff, write_row_in;
   logic [IDX_W-1:0] write_col_ff, write_col_in;
   logic [IDX_W-1:0] read_row_ff, read_row_in;
   logic [IDX_W-1:0] read_col_ff, read_col_in;
   logic             write_bank_ff, write_bank_in;
   logic             filled_ff, filled_in;

   logic             restart;
   logic [IDX_W-1:0] orow_last;
   logic [IDX_W-1:0] ocol_last;
   logic [IDX_W-1:0] src_row;
   logic [IDX_W-1:0] src_col;
   logic             read_eor;
   logic             read_eof;
   logic             write_eor;
   logic             write_eof;

   always_comb begin
      row_last_in = row_last_ff;
      col_last_in = col_last_ff;
      turns_in = turns_ff;
      restart = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_ROWS: begin
               row_last_in = last_index(csr_wdata, MAX_ROWS);
               restart = 1'b1;
            end
            CSR_FRAME_COLS: begin
               col_last_in = last_index(csr_wdata, MAX_COLS);
               restart = 1'b1;
            end
            CSR_QUARTER_TURNS: begin
               turns_in = turn_type'(csr_wdata[TURN_W-1:0]);
               restart = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Odd turn counts swap the output row and column counts.
   assign orow_last = turns_ff[0] ? col_last_ff : row_last_ff;
   assign ocol_last = turns_ff[0] ? row_last_ff : col_last_ff;

   always_comb begin
      unique case (turns_ff)
         TURN_0: begin
            src_row = read_row_ff;
            src_col = read_col_ff;
         end
         TURN_90: begin
            src_row = row_last_ff - read_col_ff;
            src_col = read_row_ff;
         end
         TURN_180: begin
            src_row = row_last_ff - read_row_ff;
            src_col = col_last_ff - read_col_ff;
         end
         TURN_270: begin
            src_row = read_col_ff;
            src_col = col_last_ff - read_row_ff;
         end
         default: begin
            src_row = read_row_ff;
            src_col = read_col_ff;
         end
      endcase
   end

   assign read_eor = (read_col_ff == ocol_last);
   assign read_eof = read_eor && (read_row_ff == orow_last);
   assign write_eor = (write_col_ff == col_last_ff);
   assign write_eof = write_eor && (write_row_ff == row_last_ff);

   always_comb begin
      write_row_in = write_row_ff;
      write_col_in = write_col_ff;
      read_row_in = read_row_ff;
      read_col_in = read_col_ff;
      write_bank_in = write_bank_ff;
      filled_in = filled_ff;
      if (restart) begin
         write_row_in = '0;
         write_col_in = '0;
         read_row_in = '0;
         read_col_in = '0;
         filled_in = 1'b0;
      end else if (accept) begin
         read_col_in = read_eor ? '0 : read_col_ff + 1'b1;
         if (read_eor) begin
            read_row_in = read_eof ? '0 : read_row_ff + 1'b1;
         end
         write_col_in = write_eor ? '0 : write_col_ff + 1'b1;
         if (write_eor) begin
            write_row_in = write_eof ? '0 : write_row_ff + 1'b1;
         end
         if (write_eof) begin
            write_bank_in = ~write_bank_ff;
            filled_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_last_ff <= last_index(RESET_ROWS, MAX_ROWS);
         col_last_ff <= last_index(RESET_COLS, MAX_COLS);
         turns_ff <= TURN_0;
         write_row_ff <= '0;
         write_col_ff <= '0;
         read_row_ff <= '0;
         read_col_ff <= '0;
         write_bank_ff <= 1'b0;
         filled_ff <= 1'b0;
      end else begin
         row_last_ff <= row_last_in;
         col_last_ff <= col_last_in;
         turns_ff <= turns_in;
         write_row_ff <= write_row_in;
         write_col_ff <= write_col_in;
         read_row_ff <= read_row_in;
         read_col_ff <= read_col_in;
         write_bank_ff <= write_bank_in;
         filled_ff <= filled_in;
      end
   end

   assign access.rd_addr = {~write_bank_ff, src_row, src_col};
   assign access.wr_addr = {write_bank_ff, write_row_ff, write_col_ff};
   assign access.filled = filled_ff;
   assign access.end_of_row = read_eor;
   assign access.end_of_frame = read_eof;

endmodule

[src/frame_rotate_quarter_turns_unit.sv]
// Double-buffered frame rotator. Pixels enter in raster order and are written into one bank
// of a two-bank frame memory while the previous frame is read from the other bank, turned
// clockwise by 0, 1, 2 or 3 quarter turns; every accepted word yields one result word. The
// unit takes one word per clock unless the output stalls; each result passes the memory read
// register, then the output register; memory does one write and one read per accepted word.
// Results are invalid, with zero color, until a full frame is stored, so the memory needs no
// clearing after reset. Writing a defined register restarts the frame at the first pixel.
module frame_rotate_quarter_turns_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [frot_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [frot_pkg::CSR_DATA_W-1:0] csr_wdata,
   frot_req_if.sink                        req_px,
   frot_rsp_if.source                      rsp_px
);
   import frot_pkg::*;

   frot_access_type  access;
   logic             accept;
   logic             s1_load_out;
   logic             s1_free;
   logic [PIX_W-1:0] rd_data;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_filled_ff;
   logic             s1_eor_ff;
   logic             s1_eof_ff;

   logic             s2_valid_ff, s2_valid_in;
   logic [PIX_W-1:0] s2_pixel_ff;
   logic             s2_filled_ff;
   logic             s2_eor_ff;
   logic             s2_eof_ff;

   frot_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .access    (access)
   );

   frot_frame_ram u_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (access.wr_addr),
      .wr_data ({req_px.in_red, req_px.in_green, req_px.in_blue}),
      .rd_en   (accept),
      .rd_addr (access.rd_addr),
      .rd_data (rd_data)
   );

   // Stage one is the memory read register; stage two is the output register.
   assign s1_load_out = s1_valid_ff && (!s2_valid_ff || rsp_px.ready);
   assign s1_free = !s1_valid_ff || s1_load_out;
   assign accept = req_px.valid && s1_free;
   assign req_px.ready = s1_free;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_load_out);
   assign s2_valid_in = s1_load_out || (s2_valid_ff && !rsp_px.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_filled_ff <= access.filled;
         s1_eor_ff <= access.end_of_row;
         s1_eof_ff <= access.end_of_frame;
      end
      if (s1_load_out) begin
         s2_pixel_ff <= s1_filled_ff ? rd_data : '0;
         s2_filled_ff <= s1_filled_ff;
         s2_eor_ff <= s1_eor_ff;
         s2_eof_ff <= s1_eof_ff;
      end
   end

   assign rsp_px.valid = s2_valid_ff;
   assign rsp_px.out_red = s2_pixel_ff[3*CH_W-1:2*CH_W];
   assign rsp_px.out_green = s2_pixel_ff[2*CH_W-1:CH_W];
   assign rsp_px.out_blue = s2_pixel_ff[CH_W-1:0];
   assign rsp_px.out_valid = s2_filled_ff;
   assign rsp_px.end_of_row = s2_eor_ff;
   assign rsp_px.end_of_frame = s2_eof_ff;

   // The read and the write of one word always go to opposite banks.
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      accept |-> (access.rd_addr[ADDR_W-1] != access.wr_addr[ADDR_W-1]))
      else $error("read and write hit the same frame bank");

   // A frame end is always also a row end.
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_px.valid |-> (!rsp_px.end_of_frame || rsp_px.end_of_row))
      else $error("end of frame without end of row");

   // A write to a defined register restarts the frame, so the next word is flagged invalid.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == CSR_FRAME_ROWS || csr_index == CSR_FRAME_COLS ||
                  csr_index == CSR_QUARTER_TURNS)) |=> !access.filled)
      else $error("register write did not restart the frame");

   // An invalid result carries no color.
   a_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_px.valid && !rsp_px.out_valid) |->
         (rsp_px.out_red == '0 && rsp_px.out_green == '0 && rsp_px.out_blue == '0))
      else $error("color on an invalid result");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import frot_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_PIXELS = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            valid;
      logic            end_of_row;
      logic            end_of_frame;
   } rotated_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   frot_req_if req_if ();
   frot_rsp_if rsp_if ();

   frame_rotate_quarter_turns_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_px    (req_if),
      .rsp_px    (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Local copy of the rotator: two banks, raster counters and register settings.
   logic [PIX_W-1:0]  frame_mem [0:2*MAX_ROWS*MAX_COLS-1];
   logic [SIZE_W-1:0] cfg_rows;
   logic [SIZE_W-1:0] cfg_cols;
   logic [TURN_W-1:0] cfg_turns;
   int unsigned       wr_row, wr_col, rd_row, rd_col;
   bit                wr_bank;
   bit                bank_filled;

   rotated_pixel_type pending_pixels[$];
   int                failures = 0;
   int                pixels_sent = 0;
   int                pixels_checked = 0;
   int                settings_used = 0;
   bit                steady_flow = 1'b0;
   int                hold_off_cycles = 0;

   function automatic int unsigned eff_size(input logic [SIZE_W-1:0] size,
                                            input int unsigned bound);
      if (size == '0) return 1;
      return (size > bound) ? bound : size;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_FRAME_ROWS: cfg_rows = data;
         CSR_FRAME_COLS: cfg_cols = data;
         CSR_QUARTER_TURNS: cfg_turns = data[TURN_W-1:0];
         default: return;
      endcase
      // Any real register write starts a new frame; the bank select survives.
      wr_row = 0;
      wr_col = 0;
      rd_row = 0;
      rd_col = 0;
      bank_filled = 1'b0;
   endfunction

   function automatic rotated_pixel_type rotate_step(input logic [PIX_W-1:0] px_in);
      rotated_pixel_type result;
      int unsigned       nrows, ncols, orows, ocols, src_row, src_col, rd_idx, wr_idx;
      logic [PIX_W-1:0]  stored;
      nrows = eff_size(cfg_rows, MAX_ROWS);
      ncols = eff_size(cfg_cols, MAX_COLS);
      orows = cfg_turns[0] ? ncols : nrows;
      ocols = cfg_turns[0] ? nrows : ncols;
      case (turn_type'(cfg_turns))
         TURN_0: begin
            src_row = rd_row;
            src_col = rd_col;
         end
         TURN_90: begin
            src_row = nrows - 1 - rd_col;
            src_col = rd_row;
         end
         TURN_180: begin
            src_row = nrows - 1 - rd_row;
            src_col = ncols - 1 - rd_col;
         end
         default: begin
            src_row = rd_col;
            src_col = ncols - 1 - rd_row;
         end
      endcase
      // Colors read as zero until a whole frame sits in the read bank.
      stored = '0;
      if (bank_filled) begin
         rd_idx = (wr_bank ? 0 : MAX_ROWS * MAX_COLS) + src_row * MAX_COLS + src_col;
         stored = frame_mem[rd_idx];
      end
      result.red = stored[PIX_W-1 -: CH_W];
      result.green = stored[2*CH_W-1 -: CH_W];
      result.blue = stored[CH_W-1:0];
      result.valid = bank_filled;
      result.end_of_row = (rd_col + 1 >= ocols);
      result.end_of_frame = result.end_of_row && (rd_row + 1 >= orows);

      wr_idx = (wr_bank ? MAX_ROWS * MAX_COLS : 0) + wr_row * MAX_COLS + wr_col;
      frame_mem[wr_idx] = px_in;

      if (rd_col + 1 < ocols) begin
         rd_col++;
      end else begin
         rd_col = 0;
         rd_row = (rd_row + 1 < orows) ? rd_row + 1 : 0;
      end
      if (wr_col + 1 < ncols) begin
         wr_col++;
      end else begin
         wr_col = 0;
         if (wr_row + 1 < nrows) begin
            wr_row++;
         end else begin
            wr_row = 0;
            wr_bank = !wr_bank;
            bank_filled = 1'b1;
         end
      end
      return result;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return SIZE_W'($urandom_range(1, 6));
      if (roll < 95) return SIZE_W'($urandom_range(7, 16));
      return '0;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         failures++;
         $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Leaves valid high after acceptance so the next word can follow back to back.
   task automatic send_pixel(input logic [PIX_W-1:0] px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      {req_if.in_red, req_if.in_green, req_if.in_blue} <= px;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_pixels.push_back(rotate_step(px));
      pixels_sent++;
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write enable stays high across back-to-back writes; callers lower it.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic program_frame(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                                input logic [CSR_DATA_W-1:0] turns_word);
      write_csr(CSR_FRAME_ROWS, rows);
      write_csr(CSR_FRAME_COLS, cols);
      write_csr(CSR_QUARTER_TURNS, turns_word);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic test_invalid_output();
      // Default 256 x 256 frame: nothing stored yet, so every word comes back blank.
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hAA55AA);
      send_pixel(24'h55AA55);
      wait_drain();
   endtask

   task automatic test_each_turn();
      for (int t = 0; t < 4; t++) begin
         program_frame(SIZE_W'(2), SIZE_W'(1), CSR_DATA_W'(t));
         send_pixel(24'hFF00FF);
         send_pixel(24'h00FF00);
         send_pixel(PIX_W'($urandom));
         send_pixel(PIX_W'($urandom));
         wait_drain();
      end
   endtask

   task automatic test_unused_index();
      program_frame(SIZE_W'(1), SIZE_W'(2), CSR_DATA_W'(TURN_180));
      repeat (3) send_pixel(PIX_W'($urandom));
      wait_drain();
      // Index three is not a register, so the frame in progress must carry on.
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
      repeat (3) send_pixel(PIX_W'($urandom));
      wait_drain();
   endtask

   task automatic test_frame_restart();
      program_frame(SIZE_W'(1), SIZE_W'(2), CSR_DATA_W'(TURN_0));
      repeat (3) send_pixel(PIX_W'($urandom));
      wait_drain();
      // Rewriting an unchanged value still drops the stored frame.
      write_csr(CSR_FRAME_COLS, SIZE_W'(2));
      csr_we <= 1'b0;
      repeat (3) send_pixel(PIX_W'($urandom));
      wait_drain();
   endtask

   task automatic test_size_extremes();
      program_frame('0, '0, CSR_DATA_W'(TURN_90));
      repeat (3) send_pixel(PIX_W'($urandom));
      wait_drain();
      // An oversize row count saturates, so one full column frame then a few stored words.
      program_frame('1, SIZE_W'(1), CSR_DATA_W'($urandom));
      repeat (MAX_ROWS + 8) send_pixel(PIX_W'($urandom));
      wait_drain();
   endtask

   task automatic test_backpressure();
      program_frame(SIZE_W'(3), SIZE_W'(4), CSR_DATA_W'(TURN_270));
      steady_flow = 1'b1;
      hold_off_cycles = 200;
      repeat (40) send_pixel(PIX_W'($urandom));
      // Pause the sender until every word is back, then resume the same frame.
      wait_drain();
      repeat (30) send_pixel(PIX_W'($urandom));
      steady_flow = 1'b0;
      wait_drain();
   endtask

   task automatic test_random_frames();
      int                frame_words;
      int                count;
      int                total;
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
      total = 0;
      while (total < RANDOM_PIXELS) begin
         rows = pick_size();
         cols = pick_size();
         if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
         program_frame(rows, cols, CSR_DATA_W'($urandom));
         steady_flow = ($urandom_range(0, 3) == 0);
         frame_words = eff_size(rows, MAX_ROWS) * eff_size(cols, MAX_COLS);
         count = frame_words * $urandom_range(1, 3) + $urandom_range(0, frame_words);
         repeat (count) send_pixel(PIX_W'($urandom));
         total += count;
         wait_drain();
      end
      steady_flow = 1'b0;
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.in_red <= '0;
      req_if.in_green <= '0;
      req_if.in_blue <= '0;
      cfg_rows = RESET_ROWS;
      cfg_cols = RESET_COLS;
      cfg_turns = TURN_0;
      wr_row = 0;
      wr_col = 0;
      rd_row = 0;
      rd_col = 0;
      wr_bank = 1'b0;
      bank_filled = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_invalid_output();
      test_each_turn();
      test_unused_index();
      test_frame_restart();
      test_size_extremes();
      test_backpressure();
      test_random_frames();

      $display("Sent %0d pixels over %0d frame settings: all four turns, sizes 1 to 256,",
               pixels_sent, settings_used);
      $display("zero and oversize size codes, long output stalls; %0d words checked.",
               pixels_checked);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : result_checker
      int                stall_left;
      int                gap;
      rotated_pixel_type want;
      rotated_pixel_type got;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset == 1'b0 && rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue,
                   rsp_if.out_valid, rsp_if.end_of_row, rsp_if.end_of_frame};
            if (pending_pixels.size() == 0) begin
               failures++;
               $display("time %0t: unexpected word, expected none, actual %h", $time, got);
            end else begin
               want = pending_pixels.pop_front();
               check_field("out_red", want.red, got.red);
               check_field("out_green", want.green, got.green);
               check_field("out_blue", want.blue, got.blue);
               check_field("out_valid", want.valid, got.valid);
               check_field("end_of_row", want.end_of_row, got.end_of_row);
               check_field("end_of_frame", want.end_of_frame, got.end_of_frame);
               pixels_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_off_cycles > 0) begin
            stall_left = hold_off_cycles - 1;
            hold_off_cycles = 0;
            rsp_if.ready <= 1'b0;
         end else begin
            gap = pick_gap();
            stall_left = (gap > 0) ? gap - 1 : 0;
            rsp_if.ready <= (gap == 0);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Timeout after %0d cycles with no word moving", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule
